// ===== hdl/sdbe_pkg.sv =====
package sdbe_pkg;

    localparam int DATA_W    = 16;
    localparam int THR_W     = 16;
    localparam int WIN_W     = 11;
    localparam int CNT_W     = 12;
    localparam int SUM_W     = 27;
    localparam int STAT_W    = 2;
    localparam int BIT_W     = $clog2(SUM_W);
    localparam int ADDR_W    = 4;
    localparam int APB_W     = 32;

    localparam logic [WIN_W-1:0] WIN_MAX = WIN_W'(1024);

    // register reset values
    localparam logic [THR_W-1:0] THR_X_RST = THR_W'(100);
    localparam logic [THR_W-1:0] THR_Y_RST = THR_W'(200);
    localparam logic [THR_W-1:0] THR_Z_RST = THR_W'(100);
    localparam logic [WIN_W-1:0] WIN_RST   = WIN_W'(3);

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_THR_X = 2'd0,
        REG_THR_Y = 2'd1,
        REG_THR_Z = 2'd2,
        REG_WIN   = 2'd3
    } t_reg_idx;

    // motion status codes
    typedef enum logic [STAT_W-1:0] {
        ST_MOVING     = 2'd0,
        ST_COLLECTING = 2'd1,
        ST_STATIONARY = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [DATA_W-1:0] accel_x;
        logic signed [DATA_W-1:0] accel_y;
        logic signed [DATA_W-1:0] accel_z;
    } t_in_req;

    typedef struct packed {
        logic [STAT_W-1:0]        motion_status;
        logic signed [DATA_W-1:0] bias_x;
        logic signed [DATA_W-1:0] bias_y;
        logic signed [DATA_W-1:0] bias_z;
        logic                     bias_updated;
    } t_out_req;

endpackage

// ===== hdl/stillness_detect_bias_estimator_top.sv =====
// channel   direction  handshake                 payload
// in        input      i_in_valid / o_in_stall   i_in_req  (accel_x, accel_y, accel_z)
// out       output     o_out_valid / i_out_stall o_out_req (motion_status, bias_*, bias_updated)
// cfg       input      psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// a request runs the serial threshold/sum pass, which walks 27 bits one per
// cycle; when the request completes a bias estimate, the restoring divider
// follows, producing one quotient bit per axis per cycle
// one request is in work at a time; the next is taken once the previous
// result sits in the output register, even while it is stalled there
// reset is synchronous, active low, and needs no clearing pass

module stillness_detect_bias_estimator_top
    import sdbe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_req           i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_req          o_out_req,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]  pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_DECIDE = 6'b000100,
        S_DIV    = 6'b001000,
        S_BIAS   = 6'b010000,
        S_EMIT   = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration registers
    logic [THR_W-1:0] r_thr [3];
    logic [WIN_W-1:0] r_win;

    // item state
    logic signed [DATA_W-1:0] r_prev [3];
    logic signed [SUM_W-1:0]  r_sum  [3];
    logic signed [DATA_W-1:0] r_bias [3];
    logic [CNT_W-1:0]         r_qc;
    t_status                  r_status;
    logic                     r_upd;

    // serial datapath
    logic [DATA_W-1:0] r_sh_a [3];
    logic [DATA_W-1:0] r_sh_p [3];
    logic [THR_W-1:0]  r_sh_t [3];
    logic [SUM_W-1:0]  r_sh_s [3];
    logic [SUM_W-1:0]  r_cand [3];
    logic [3:0]        r_cy   [3];
    logic [2:0]        r_flag [3];
    logic [BIT_W-1:0]  r_bit;

    // divider
    logic [SUM_W-1:0] r_dv  [3];
    logic [CNT_W-1:0] r_rem [3];
    logic [2:0]       r_neg;

    // output register
    logic     r_out_valid;
    t_out_req r_out;

    logic             w_accept;
    logic             w_cfg_wr;
    logic             w_bit_last;
    logic             w_out_free;
    logic [WIN_W-1:0] w_win;
    logic [CNT_W-1:0] w_win2;
    logic [CNT_W-1:0] w_qc_inc;
    logic             w_motion;
    logic [2:0]       w_ax_motion;

    logic [3:0] w_cy_n  [3];
    logic [3:0] w_bits  [3];
    logic [CNT_W-1:0] w_rem_sh [3];
    logic             w_ge     [3];

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_bit_last = (r_bit == BIT_W'(SUM_W - 1));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign pready     = 1'b1;

    // effective window: zero acts as one, large values clamp
    always_comb begin
        if (r_win == '0) begin
            w_win = WIN_W'(1);
        end else if (r_win > WIN_MAX) begin
            w_win = WIN_MAX;
        end else begin
            w_win = r_win;
        end
    end
    assign w_win2   = {w_win, 1'b0};
    assign w_qc_inc = r_qc + CNT_W'(1);

    // register read
    always_comb begin
        prdata = '0;
        case (t_reg_idx'(paddr[3:2]))
            REG_THR_X: prdata = APB_W'(r_thr[0]);
            REG_THR_Y: prdata = APB_W'(r_thr[1]);
            REG_THR_Z: prdata = APB_W'(r_thr[2]);
            REG_WIN:   prdata = APB_W'(r_win);
            default:   prdata = '0;
        endcase
    end

    // per-axis serial adders and divider step
    // bits: [0] a-p, [1] a-p-t, [2] a-p+t, [3] sum+a
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic a_b, np_b, t_b, s_b, d_b;
            a_b  = r_sh_a[i][0];
            np_b = ~r_sh_p[i][0];
            t_b  = r_sh_t[i][0];
            s_b  = r_sh_s[i][0];
            d_b  = a_b ^ np_b ^ r_cy[i][0];
            w_bits[i][0] = d_b;
            w_cy_n[i][0] = (a_b & np_b) | (a_b & r_cy[i][0]) | (np_b & r_cy[i][0]);
            w_bits[i][1] = d_b ^ ~t_b ^ r_cy[i][1];
            w_cy_n[i][1] = (d_b & ~t_b) | (d_b & r_cy[i][1]) | (~t_b & r_cy[i][1]);
            w_bits[i][2] = d_b ^ t_b ^ r_cy[i][2];
            w_cy_n[i][2] = (d_b & t_b) | (d_b & r_cy[i][2]) | (t_b & r_cy[i][2]);
            w_bits[i][3] = s_b ^ a_b ^ r_cy[i][3];
            w_cy_n[i][3] = (s_b & a_b) | (s_b & r_cy[i][3]) | (a_b & r_cy[i][3]);

            w_rem_sh[i] = {r_rem[i][CNT_W-2:0], r_dv[i][SUM_W-1]};
            w_ge[i]     = (w_rem_sh[i] >= CNT_W'(w_win));
        end
    end

    // motion: a-p-t above zero or a-p+t below zero on any axis
    // flag: [0] a-p-t nonzero, [1] a-p-t sign, [2] a-p+t sign
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_ax_motion[i] = (!r_flag[i][1] && r_flag[i][0]) || r_flag[i][2];
        end
    end
    assign w_motion = |w_ax_motion;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_accept) n_state = S_SCAN;
            S_SCAN:   if (w_bit_last) n_state = S_DECIDE;
            S_DECIDE: begin
                if (!w_motion && r_qc >= CNT_W'(w_win) && r_qc < w_win2
                        && w_qc_inc == w_win2) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_DIV:    if (w_bit_last) n_state = S_BIAS;
            S_BIAS:   n_state = S_EMIT;
            S_EMIT:   if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr[0]    <= THR_X_RST;
            r_thr[1]    <= THR_Y_RST;
            r_thr[2]    <= THR_Z_RST;
            r_win       <= WIN_RST;
            r_qc        <= '0;
            r_status    <= ST_MOVING;
            r_upd       <= 1'b0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_prev[i] <= '0;
                r_sum[i]  <= '0;
                r_bias[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            // config write
            if (w_cfg_wr) begin
                case (t_reg_idx'(paddr[3:2]))
                    REG_THR_X: r_thr[0] <= pwdata[THR_W-1:0];
                    REG_THR_Y: r_thr[1] <= pwdata[THR_W-1:0];
                    REG_THR_Z: r_thr[2] <= pwdata[THR_W-1:0];
                    REG_WIN:   r_win    <= pwdata[WIN_W-1:0];
                    default:   ;
                endcase
            end

            // sample becomes the reference for the next one
            if (w_accept) begin
                r_prev[0] <= i_in_req.accel_x;
                r_prev[1] <= i_in_req.accel_y;
                r_prev[2] <= i_in_req.accel_z;
            end

            // bit counter shared by scan and divide
            if (r_state == S_SCAN || r_state == S_DIV) begin
                r_bit <= w_bit_last ? '0 : r_bit + BIT_W'(1);
            end

            // counter and status update
            if (r_state == S_DECIDE) begin
                r_upd <= 1'b0;
                if (w_motion) begin
                    r_qc     <= '0;
                    r_status <= ST_MOVING;
                    for (int i = 0; i < 3; i++) r_sum[i] <= '0;
                end else if (r_qc < CNT_W'(w_win)) begin
                    r_qc     <= w_qc_inc;
                    r_status <= ST_MOVING;
                end else if (r_qc < w_win2) begin
                    r_qc <= w_qc_inc;
                    for (int i = 0; i < 3; i++) r_sum[i] <= r_cand[i];
                    if (w_qc_inc == w_win2) begin
                        r_status <= ST_STATIONARY;
                        r_upd    <= 1'b1;
                    end else begin
                        r_status <= ST_COLLECTING;
                    end
                end else begin
                    r_qc     <= w_win2;
                    r_status <= ST_STATIONARY;
                end
            end

            // signed quotient from magnitude
            if (r_state == S_BIAS) begin
                for (int i = 0; i < 3; i++) begin
                    r_bias[i] <= r_neg[i] ? -r_dv[i][DATA_W-1:0] : r_dv[i][DATA_W-1:0];
                end
            end

            // output register
            if (r_state == S_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // serial datapath and divider
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sh_a[0] <= i_in_req.accel_x;
            r_sh_a[1] <= i_in_req.accel_y;
            r_sh_a[2] <= i_in_req.accel_z;
            for (int i = 0; i < 3; i++) begin
                r_sh_p[i] <= r_prev[i];
                r_sh_t[i] <= r_thr[i];
                r_sh_s[i] <= (r_qc == CNT_W'(w_win)) ? '0 : r_sum[i];
                // carry in: one for the two subtractions, zero for the two additions
                r_cy[i]   <= 4'b0011;
                r_flag[i] <= '0;
            end
        end else if (r_state == S_SCAN) begin
            for (int i = 0; i < 3; i++) begin
                r_sh_a[i] <= {r_sh_a[i][DATA_W-1], r_sh_a[i][DATA_W-1:1]};
                r_sh_p[i] <= {r_sh_p[i][DATA_W-1], r_sh_p[i][DATA_W-1:1]};
                r_sh_t[i] <= {1'b0, r_sh_t[i][THR_W-1:1]};
                r_sh_s[i] <= {r_sh_s[i][SUM_W-1], r_sh_s[i][SUM_W-1:1]};
                r_cand[i] <= {w_bits[i][3], r_cand[i][SUM_W-1:1]};
                r_cy[i]   <= w_cy_n[i];
                r_flag[i] <= {w_bits[i][2], w_bits[i][1], r_flag[i][0] | w_bits[i][1]};
            end
        end

        // divider load with magnitude of the new sum
        if (r_state == S_DECIDE) begin
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= r_cand[i][SUM_W-1];
                r_dv[i]  <= r_cand[i][SUM_W-1] ? -r_cand[i] : r_cand[i];
                r_rem[i] <= '0;
            end
        end else if (r_state == S_DIV) begin
            for (int i = 0; i < 3; i++) begin
                r_rem[i] <= w_ge[i] ? w_rem_sh[i] - CNT_W'(w_win) : w_rem_sh[i];
                r_dv[i]  <= {r_dv[i][SUM_W-2:0], w_ge[i]};
            end
        end

        if (r_state == S_EMIT && w_out_free) begin
            r_out.motion_status <= r_status;
            r_out.bias_x        <= r_bias[0];
            r_out.bias_y        <= r_bias[1];
            r_out.bias_z        <= r_bias[2];
            r_out.bias_updated  <= r_upd;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // checks
    a_upd_stationary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_req.bias_updated |-> o_out_req.motion_status == ST_STATIONARY)
        else $error("bias update without stationary status");

    a_qc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qc <= {WIN_MAX, 1'b0})
        else $error("quiet counter beyond twice the largest window");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall)
        else $error("second request taken while one is in work");

    a_div_only_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_BIAS |=> r_upd && r_status == ST_STATIONARY)
        else $error("divider ran without a completed estimate");

endmodule
